// ===== src/bba_pkg.sv =====
// Shared constants, types and helper functions of the buddy block allocator.
package bba_pkg;

  localparam int MAXO  = 12;              // largest block order
  localparam int IDXW  = MAXO + 1;        // heap index width
  localparam int BSW   = 5;               // bit-select width inside a map word
  localparam int WBITS = 1 << BSW;        // map word width
  localparam int WAW   = IDXW - BSW;      // map word address width
  localparam int NWORDS = 1 << WAW;       // map words
  localparam int CHW   = WAW - BSW;       // chunk index width of the non-empty mask
  localparam int KW    = 4;               // order width
  localparam int OFFW  = 12;              // offset width
  localparam int SZW   = 13;              // size width

  typedef logic [KW-1:0]   ord_t;
  typedef logic [IDXW-1:0] idx_t;
  typedef logic [WAW-1:0]  waddr_t;
  typedef logic [CHW-1:0]  chunk_t;
  typedef logic [WBITS-1:0] word_t;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOFREE = 2'd1;
  localparam logic [1:0] ST_BAD    = 2'd2;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef enum logic [3:0] {
    OP_NONE, OP_INIT, OP_LOAD, OP_SCAN, OP_PICK,
    OP_SPLIT_RD, OP_SPLIT_WR, OP_FREE_RD, OP_FREE_WR, OP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic       st_ld;
    logic [1:0] st;
  } cmd_t;

  typedef struct packed {
    logic bad;
    logic is_free;
    logic hit;
    logic last_chunk;
    logic k_at_pool;
    logic k_at_need;
    logic found;
    logic merge;
  } flags_t;

  // Heap index of the first block of order k.
  function automatic idx_t order_base(input ord_t k);
    idx_t r;
    r = '0;
    if (k <= ord_t'(MAXO)) r = idx_t'(1) << (ord_t'(MAXO) - k);
    return r;
  endfunction

  // Heap index of the last block of order k.
  function automatic idx_t order_top(input ord_t k);
    logic [IDXW:0] t;
    t = {1'b0, order_base(k)};
    t = (t << 1) - 1'b1;
    return t[IDXW-1:0];
  endfunction

  function automatic chunk_t first_chunk(input ord_t k);
    idx_t b;
    b = order_base(k);
    return b[IDXW-1 -: CHW];
  endfunction

  function automatic chunk_t last_chunk(input ord_t k);
    idx_t t;
    t = order_top(k);
    return t[IDXW-1 -: CHW];
  endfunction

  // Order of the smallest power of two not below size; zero counts as one.
  function automatic ord_t round_order(input logic [SZW-1:0] size);
    logic [SZW-1:0] v;
    ord_t n;
    v = size - 1'b1;
    n = '0;
    if (size > SZW'(1)) begin
      for (int i = 0; i < SZW; i++) begin
        if (v[i]) n = ord_t'(i + 1);
      end
    end
    return n;
  endfunction

  // Position of the lowest set bit of a word.
  function automatic logic [BSW-1:0] lowest_bit(input word_t w);
    logic [BSW-1:0] p;
    p = '0;
    for (int i = WBITS - 1; i >= 0; i--) begin
      if (w[i]) p = BSW'(i);
    end
    return p;
  endfunction

endpackage

// ===== src/bba_ctrl.sv =====
// Controller state machine of the buddy block allocator.
module bba_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_wr,
  input  logic           in_tvalid,
  output logic           in_tready,
  output logic           out_tvalid,
  input  logic           out_tready,
  input  bba_pkg::flags_t flags,
  output bba_pkg::cmd_t  cmd
);
  import bba_pkg::*;

  typedef enum logic [9:0] {
    S_INIT     = 10'b0000000001,
    S_IDLE     = 10'b0000000010,
    S_CHECK    = 10'b0000000100,
    S_SCAN     = 10'b0000001000,
    S_PICK     = 10'b0000010000,
    S_SPLIT_RD = 10'b0000100000,
    S_SPLIT_WR = 10'b0001000000,
    S_FREE_RD  = 10'b0010000000,
    S_FREE_WR  = 10'b0100000000,
    S_DONE     = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_tready  = (state_r == S_IDLE) && !cfg_wr;
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd           = '{op: OP_NONE, st_ld: 1'b0, st: ST_OK};
    unique case (state_r)
      S_INIT: begin
        cmd.op    = OP_INIT;
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (cfg_wr) begin
          state_nxt = S_INIT;
        end else if (in_tvalid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (flags.bad) begin
          cmd.st_ld = 1'b1;
          cmd.st    = ST_BAD;
          state_nxt = S_DONE;
        end else if (flags.is_free) begin
          state_nxt = S_FREE_RD;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.op = OP_SCAN;
        if (flags.hit) begin
          state_nxt = S_PICK;
        end else if (flags.last_chunk && flags.k_at_pool) begin
          cmd.st_ld = 1'b1;
          cmd.st    = ST_NOFREE;
          state_nxt = S_DONE;
        end
      end
      S_PICK: begin
        cmd.op = OP_PICK;
        if (flags.found) begin
          if (flags.k_at_need) begin
            cmd.st_ld = 1'b1;
            cmd.st    = ST_OK;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_SPLIT_RD;
          end
        end else if (flags.k_at_pool) begin
          cmd.st_ld = 1'b1;
          cmd.st    = ST_NOFREE;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SPLIT_RD: begin
        cmd.op    = OP_SPLIT_RD;
        state_nxt = S_SPLIT_WR;
      end
      S_SPLIT_WR: begin
        cmd.op = OP_SPLIT_WR;
        if (flags.k_at_need) begin
          cmd.st_ld = 1'b1;
          cmd.st    = ST_OK;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_SPLIT_RD;
        end
      end
      S_FREE_RD: begin
        cmd.op    = OP_FREE_RD;
        state_nxt = S_FREE_WR;
      end
      S_FREE_WR: begin
        cmd.op = OP_FREE_WR;
        if (!flags.merge) begin
          cmd.st_ld = 1'b1;
          cmd.st    = ST_OK;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_FREE_RD;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.op        = OP_OUT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== src/bba_dp.sv =====
// Datapath of the buddy block allocator: free map memory, search and split/merge logic.
module bba_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  bba_pkg::cmd_t               cmd,
  output bba_pkg::flags_t             flags,
  input  bba_pkg::ord_t               pool_i,
  input  logic                        req_type_i,
  input  logic [bba_pkg::SZW-1:0]     req_size_i,
  input  logic [bba_pkg::OFFW-1:0]    req_off_i,
  output logic [1:0]                  out_status,
  output logic [bba_pkg::OFFW-1:0]    out_address,
  output logic [bba_pkg::SZW-1:0]     out_size
);
  import bba_pkg::*;

  word_t          mem [NWORDS];
  logic [NWORDS-1:0] valid_r;
  logic [NWORDS-1:0] nz_r;

  logic           req_type_r;
  ord_t           need_r;
  logic [OFFW-1:0] off_in_r;
  ord_t           k_r;
  idx_t           idx_r;
  chunk_t         chunk_r;
  waddr_t         wsel_r;
  word_t          rdata_r;
  logic           rvalid_r;
  logic [OFFW-1:0] off_r;
  logic [1:0]     res_st_r;

  word_t          word_q;
  word_t          scan_bits;
  word_t          pick_bits;
  logic [BSW-1:0] scan_pos;
  logic [BSW-1:0] pick_pos;
  idx_t           pick_idx;
  idx_t           k_lo, k_hi;
  idx_t           init_idx;
  waddr_t         w_lo, w_hi;
  ord_t           k_up;
  logic           rd_en;
  waddr_t         rd_addr;
  logic           wr_en;
  waddr_t         wr_addr;
  word_t          wr_data;
  word_t          free_word;
  logic           merge;
  logic [SZW:0]   align_mask;
  logic [SZW:0]   need_pow;

  assign word_q   = rvalid_r ? rdata_r : '0;
  assign k_lo     = order_base(k_r);
  assign k_hi     = order_top(k_r);
  assign w_lo     = k_lo[IDXW-1:BSW];
  assign w_hi     = k_hi[IDXW-1:BSW];
  assign k_up     = k_r + 1'b1;
  assign init_idx = order_base(pool_i);

  // Non-empty words of the chunk and set bits of the read word, in the current order.
  always_comb begin
    for (int j = 0; j < WBITS; j++) begin
      scan_bits[j] = nz_r[{chunk_r, BSW'(j)}] &&
                     ({chunk_r, BSW'(j)} >= w_lo) && ({chunk_r, BSW'(j)} <= w_hi);
      pick_bits[j] = word_q[j] &&
                     ({wsel_r, BSW'(j)} >= k_lo) && ({wsel_r, BSW'(j)} <= k_hi);
    end
  end

  assign scan_pos = lowest_bit(scan_bits);
  assign pick_pos = lowest_bit(pick_bits);
  assign pick_idx = {wsel_r, pick_pos};

  assign need_pow   = (SZW+1)'(1) << need_r;
  assign align_mask = need_pow - 1'b1;

  always_comb begin
    free_word = word_q | (word_t'(1) << idx_r[BSW-1:0]);
    merge     = (k_r < pool_i) && word_q[idx_r[BSW-1:0] ^ BSW'(1)];
    if (merge) begin
      free_word = free_word & ~(word_t'(1) << idx_r[BSW-1:0])
                            & ~(word_t'(1) << (idx_r[BSW-1:0] ^ BSW'(1)));
    end
  end

  always_comb begin
    flags.bad        = (need_r > pool_i) ||
                       (req_type_r == REQ_FREE &&
                        ((({1'b0, off_in_r} & align_mask[SZW-1:0]) != '0) ||
                         (({1'b0, off_in_r} >> pool_i) != '0)));
    flags.is_free    = (req_type_r == REQ_FREE);
    flags.hit        = |scan_bits;
    flags.last_chunk = (chunk_r == last_chunk(k_r));
    flags.k_at_pool  = (k_r == pool_i);
    flags.k_at_need  = (k_r == need_r);
    flags.found      = |pick_bits;
    flags.merge      = merge;
  end

  // Memory access decode.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    case (cmd.op)
      OP_INIT: begin
        wr_en   = 1'b1;
        wr_addr = init_idx[IDXW-1:BSW];
        wr_data = word_t'(1) << init_idx[BSW-1:0];
      end
      OP_SCAN: begin
        rd_en   = |scan_bits;
        rd_addr = {chunk_r, scan_pos};
      end
      OP_PICK: begin
        wr_en   = |pick_bits;
        wr_addr = wsel_r;
        wr_data = word_q & ~(word_t'(1) << pick_pos);
      end
      OP_SPLIT_RD: begin
        rd_en   = 1'b1;
        rd_addr = idx_r[IDXW-2 -: WAW];
      end
      OP_SPLIT_WR: begin
        wr_en   = 1'b1;
        wr_addr = idx_r[IDXW-1:BSW];
        wr_data = word_q | (word_t'(1) << (idx_r[BSW-1:0] | BSW'(1)));
      end
      OP_FREE_RD: begin
        rd_en   = 1'b1;
        rd_addr = idx_r[IDXW-1:BSW];
      end
      OP_FREE_WR: begin
        wr_en   = 1'b1;
        wr_addr = idx_r[IDXW-1:BSW];
        wr_data = free_word;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
      wsel_r  <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      nz_r     <= '0;
      rvalid_r <= 1'b0;
    end else begin
      if (rd_en) rvalid_r <= valid_r[rd_addr];
      if (cmd.op == OP_INIT) begin
        // Only the word that holds the whole-pool block stays valid.
        valid_r <= NWORDS'(1) << wr_addr;
        nz_r    <= NWORDS'(1) << wr_addr;
      end else if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
        nz_r[wr_addr]    <= |wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.st_ld) res_st_r <= cmd.st;
    case (cmd.op)
      OP_LOAD: begin
        req_type_r <= req_type_i;
        need_r     <= round_order(req_size_i);
        off_in_r   <= req_off_i;
        k_r        <= round_order(req_size_i);
        chunk_r    <= first_chunk(round_order(req_size_i));
        idx_r      <= order_base(round_order(req_size_i)) +
                      idx_t'({1'b0, req_off_i} >> round_order(req_size_i));
      end
      OP_SCAN: begin
        if (!(|scan_bits)) begin
          if (chunk_r == last_chunk(k_r)) begin
            if (k_r != pool_i) begin
              k_r     <= k_up;
              chunk_r <= first_chunk(k_up);
            end
          end else begin
            chunk_r <= chunk_r + 1'b1;
          end
        end
      end
      OP_PICK: begin
        if (|pick_bits) begin
          idx_r <= pick_idx;
          off_r <= OFFW'((pick_idx - k_lo) << k_r);
        end else if (k_r != pool_i) begin
          k_r     <= k_up;
          chunk_r <= first_chunk(k_up);
        end
      end
      OP_SPLIT_RD: begin
        idx_r <= {idx_r[IDXW-2:0], 1'b0};
        k_r   <= k_r - 1'b1;
      end
      OP_FREE_WR: begin
        if (merge) begin
          idx_r <= idx_r >> 1;
          k_r   <= k_up;
        end
      end
      OP_OUT: begin
        out_status  <= res_st_r;
        out_address <= (res_st_r == ST_OK && req_type_r == REQ_ALLOC) ? off_r : '0;
        out_size    <= (res_st_r == ST_OK) ? need_pow[SZW-1:0] : '0;
      end
      default: ;
    endcase
  end

  a_split_above_need: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_SPLIT_RD |-> k_r > need_r)
    else $error("split started at or below the requested order");

  a_scan_within_pool: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_SCAN |-> k_r <= pool_i)
    else $error("order search ran past the pool order");

  a_pick_after_hit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_PICK |-> $past(cmd.op == OP_SCAN && (|scan_bits)))
    else $error("word pick without a preceding chunk hit");

endmodule

// ===== src/buddy_block_allocator.sv =====
// Top level of the buddy block allocator: stream ports, configuration port and block wiring.
//
// Each request beat yields exactly one result beat. The free map of 8191 bits (one per block
// of every order, heap indexed) sits in a 256 x 32-bit memory with one read and one write
// port; words never written since the last pool reset read as zero through per-word valid
// bits, and a per-word non-empty mask lets the search skip 32 words per cycle. A failed check
// passes through the check state, then the output state. An allocate runs the check, then the
// order search, then a split read and a split write per split level, then the output step.
// The search spends a scan step per mask chunk of each order tried (four chunks for order 0,
// two for order 1, one for each order above) and one more pick step on a hit; orders 8 and up
// share one memory word, so each of them costs a scan step and a pick step whenever that word
// is non-empty. The longest allocate is a one-byte request when only the whole 4096-byte pool
// is free. A free runs the check, then a free read and a free write for its own order and for
// each order climbed while merging, then the output step. The next request is taken in the
// cycle after the result is loaded, even while that result still waits in the output register.
// Writing pool_order while idle, and reset, re-initialise the pool, and no request is accepted
// until that init step is done.
module buddy_block_allocator (
  input  logic        clk,
  input  logic        rst_n,
  // Request stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [12:0] request_size, [24:13] block_offset
  input  logic [0:0]  in_tuser,   // [0] req_type
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [11:0] address, [24:12] granted_size
  output logic [1:0]  out_tuser,  // [1:0] status
  // Configuration port.
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import bba_pkg::*;

  localparam logic REG_POOL_ORDER = 1'b0;

  ord_t            pool_r, pool_nxt;
  logic            cfg_wr;
  cmd_t            cmd;
  flags_t          flags;
  logic [1:0]      res_status;
  logic [OFFW-1:0] res_address;
  logic [SZW-1:0]  res_size;

  // The pool order register is written on the access phase from the low order-width
  // bits of the write data; values above the largest order saturate.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr[2] == REG_POOL_ORDER);
  assign pool_nxt   = (cfg_pwdata[KW-1:0] > ord_t'(MAXO)) ? ord_t'(MAXO) : cfg_pwdata[KW-1:0];
  assign cfg_prdata = (cfg_paddr[2] == REG_POOL_ORDER) ? {{(32-KW){1'b0}}, pool_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_r <= ord_t'(MAXO);
    end else if (cfg_wr) begin
      pool_r <= pool_nxt;
    end
  end

  bba_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr     (cfg_wr),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .flags      (flags),
    .cmd        (cmd)
  );

  bba_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .flags       (flags),
    .pool_i      (pool_r),
    .req_type_i  (in_tuser[0]),
    .req_size_i  (in_tdata[SZW-1:0]),
    .req_off_i   (in_tdata[SZW +: OFFW]),
    .out_status  (res_status),
    .out_address (res_address),
    .out_size    (res_size)
  );

  assign out_tuser = res_status;
  assign out_tdata = {7'd0, res_size, res_address};

endmodule
